>>> hdl/decimal_calculator_arithmetic_unit_assert.svh
// Assertion macros for the decimal calculator arithmetic unit.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef DECIMAL_CALCULATOR_ARITHMETIC_UNIT_ASSERT_SVH
`define DECIMAL_CALCULATOR_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DCALC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define DCALC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DCALC_ASSERT_IMP(lbl, ante, cons, msg)
`define DCALC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/dcalc_pkg.sv
// Shared constants, operation codes and sequencer states for the decimal calculator.
// No dependencies.
`default_nettype none
package dcalc_pkg;
   localparam int MAG_WIDTH_DEF = 64;
   localparam int OPND_W = 34;
   localparam int PT_W = 4;
   localparam int RPT_W = 5;
   localparam int LIM_W = 4;
   localparam int KIND_W = 3;
   localparam int DIGIT_W = 4;
   localparam int RMAG_W = 64;
   localparam int POW_W = 54;
   localparam int CNT_W = 5;
   localparam int COL_W = 7;
   localparam logic [LIM_W-1:0] LIM_RESET = 4'd10;

   localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
   localparam logic [KIND_W-1:0] KIND_APP_INT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_APP_FRAC = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE, S_ALIGN, S_ARITH, S_DCHK, S_DIV_WAIT, S_MUL_WAIT, S_TRIM, S_TRIM_WAIT,
      S_CINIT, S_COUNT, S_CUT, S_SCALE, S_SCALE_WAIT, S_FRAC, S_FSUB, S_APPEND, S_DONE
   } state_type;
endpackage
`default_nettype wire

>>> hdl/dcalc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dcalc_pkg for the default width.
`default_nettype none
module dcalc_div #(
   parameter int W = dcalc_pkg::MAG_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   import dcalc_pkg::*;
   localparam int CW = $clog2(W);

   logic [W-1:0]  quot_ff, rem_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [W:0]    trial;
   logic          fits;

   assign trial = {rem_ff, quot_ff[W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[W-2:0], fits};
         rem_ff  <= fits ? W'(trial - {1'b0, dvs_ff}) : trial[W-1:0];
         cnt_ff  <= cnt_ff + CW'(1);
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> hdl/dcalc_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, product wraps to W bits.
// Depends on dcalc_pkg for operand width.
`default_nettype none
module dcalc_mul #(
   parameter int W = dcalc_pkg::MAG_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dcalc_pkg::OPND_W-1:0] a,
   input  logic [dcalc_pkg::OPND_W-1:0] b,
   output logic                        done,
   output logic [W-1:0]                product
);
   import dcalc_pkg::*;
   localparam int CW = $clog2(OPND_W);

   logic [W-1:0]      acc_ff, ash_ff;
   logic [OPND_W-1:0] bsh_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(OPND_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         ash_ff <= W'(a);
         bsh_ff <= b;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= bsh_ff[0] ? acc_ff + ash_ff : acc_ff;
         ash_ff <= ash_ff << 1;
         bsh_ff <= bsh_ff >> 1;
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

>>> hdl/decimal_calculator_arithmetic_unit.sv
// Top level of the decimal calculator: sequencer, magnitude datapath, configuration.
// Depends on dcalc_pkg, dcalc_div, dcalc_mul and the assertion macro header.
//
//   channel | ports                          | handshake
//   input   | req_*                          | start high while busy low
//   result  | rsp_*                          | rsp_valid, one cycle, no back-pressure
//   config  | csr_column_limit               | csr_valid and csr_ready
//
// Each division by ten in trailing-zero trimming or fractional cutting runs in the
// shared bit-serial divider, as does a divide, which then adds fraction digits one
// by one; a multiply runs in the shift-add multiplier, and alignment scales one
// operand by ten per point of difference.
// Reset is synchronous; it returns the sequencer to idle and column_limit to ten.
// The result strobe lasts one cycle and busy stays high until it has been shown.
`default_nettype none
`include "decimal_calculator_arithmetic_unit_assert.svh"
module decimal_calculator_arithmetic_unit #(
   parameter int MAG_WIDTH = dcalc_pkg::MAG_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dcalc_pkg::KIND_W-1:0]  req_kind,
   input  logic [dcalc_pkg::OPND_W-1:0]  req_a_magnitude,
   input  logic [dcalc_pkg::PT_W-1:0]    req_a_point,
   input  logic                          req_a_sign,
   input  logic [dcalc_pkg::OPND_W-1:0]  req_b_magnitude,
   input  logic [dcalc_pkg::PT_W-1:0]    req_b_point,
   input  logic                          req_b_sign,
   input  logic [dcalc_pkg::DIGIT_W-1:0] req_digit,
   output logic                          rsp_valid,
   output logic [dcalc_pkg::RMAG_W-1:0]  rsp_r_magnitude,
   output logic [dcalc_pkg::RPT_W-1:0]   rsp_r_point,
   output logic                          rsp_r_sign,
   output logic                          rsp_illegal,
   output logic                          rsp_accepted,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dcalc_pkg::LIM_W-1:0]   csr_column_limit
);
   import dcalc_pkg::*;
   localparam int W = MAG_WIDTH;

   state_type state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [W-1:0]       x_ff, x_in, y_ff, y_in, rem_ff, rem_in;
   logic [PT_W-1:0]    xp_ff, xp_in, yp_ff, yp_in;
   logic [RPT_W-1:0]   pt_ff, pt_in, d_ff, d_in;
   logic               sg_ff, sg_in, ill_ff, ill_in, acc_ff, acc_in, sub_ff, sub_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POW_W-1:0]   pow_ff, pow_in;
   logic [LIM_W-1:0]   lim_ff;

   logic               div_start, div_done, mul_start, mul_done;
   logic [W-1:0]       div_quot, div_rem, div_divisor, mul_prod;
   logic [W-1:0]       x10, y10, rem10;
   logic [POW_W-1:0]   pow10;
   logic [CNT_W-1:0]   cnt_next;
   logic               ge_pow, over_lim, cnt_stop;
   logic [5:0]         int_col;
   logic [COL_W-1:0]   tot_col, cut_d, frac_col;
   logic               cut_ok, same_sign, eff_sub, swap;

   assign x10      = (x_ff << 3) + (x_ff << 1);
   assign y10      = (y_ff << 3) + (y_ff << 1);
   assign rem10    = (rem_ff << 3) + (rem_ff << 1);
   assign pow10    = (pow_ff << 3) + (pow_ff << 1);
   assign cnt_next = cnt_ff + CNT_W'(1);
   assign ge_pow   = 64'(x_ff) >= 64'(pow_ff);
   assign over_lim = cnt_next > CNT_W'(lim_ff);
   assign cnt_stop = !ge_pow || over_lim;
   assign int_col  = ((cnt_ff > pt_ff) ? 6'(cnt_ff - pt_ff) : 6'd1) + 6'(sg_ff);
   assign tot_col  = (pt_ff != '0) ? COL_W'(int_col) + COL_W'(1) + COL_W'(pt_ff)
                                   : COL_W'(int_col);
   assign cut_d    = tot_col - COL_W'(lim_ff);
   assign cut_ok   = (pt_ff != '0) && (tot_col > COL_W'(lim_ff)) && (cut_d <= COL_W'(pt_ff));
   // During divide the integer columns were counted with no point, so the sign adds on.
   assign frac_col = COL_W'(cnt_ff) + COL_W'(sg_ff) + COL_W'(1) + COL_W'(pt_ff);

   assign same_sign = req_a_sign == req_b_sign;
   assign eff_sub   = (req_kind == KIND_ADD) ? !same_sign : same_sign;
   assign swap      = (req_kind == KIND_ADD) && !same_sign && req_a_sign;

   assign div_divisor = (state_ff == S_DCHK) ? y_ff : W'(10);

   dcalc_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (x_ff),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   dcalc_mul #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (req_a_magnitude),
      .b       (req_b_magnitude),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lim_ff   <= LIM_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            lim_ff <= csr_column_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      digit_ff <= digit_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      rem_ff   <= rem_in;
      xp_ff    <= xp_in;
      yp_ff    <= yp_in;
      pt_ff    <= pt_in;
      d_ff     <= d_in;
      sg_ff    <= sg_in;
      ill_ff   <= ill_in;
      acc_ff   <= acc_in;
      sub_ff   <= sub_in;
      cnt_ff   <= cnt_in;
      pow_ff   <= pow_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_ADD, KIND_SUB: begin
                     if (eff_sub && req_a_magnitude == req_b_magnitude &&
                         req_a_point == req_b_point) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_ALIGN;
                     end
                  end
                  KIND_MUL: state_in = S_MUL_WAIT;
                  KIND_DIV: state_in = (req_b_magnitude == '0) ? S_DONE : S_ALIGN;
                  KIND_APP_INT, KIND_APP_FRAC: state_in = S_CINIT;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ALIGN: begin
            if (xp_ff == yp_ff) begin
               state_in = (kind_ff == KIND_DIV) ? S_DCHK : S_ARITH;
            end
         end
         S_ARITH: state_in = S_TRIM;
         S_DCHK: state_in = (y_ff == '0) ? S_DONE : S_DIV_WAIT;
         S_DIV_WAIT: if (div_done) state_in = S_CINIT;
         S_MUL_WAIT: if (mul_done) state_in = S_TRIM;
         S_TRIM: state_in = (pt_ff == '0) ? S_CINIT : S_TRIM_WAIT;
         S_TRIM_WAIT: begin
            if (div_done) begin
               if (div_rem == '0 && pt_ff != RPT_W'(1)) begin
                  state_in = S_TRIM;
               end else begin
                  state_in = S_CINIT;
               end
            end
         end
         S_CINIT: state_in = S_COUNT;
         S_COUNT: begin
            if (cnt_stop) begin
               if (kind_ff == KIND_DIV) begin
                  state_in = S_FRAC;
               end else if (kind_ff == KIND_APP_INT || kind_ff == KIND_APP_FRAC) begin
                  state_in = S_APPEND;
               end else begin
                  state_in = S_CUT;
               end
            end
         end
         S_CUT: state_in = cut_ok ? S_SCALE : S_DONE;
         S_SCALE: state_in = (d_ff == '0) ? S_DONE : S_SCALE_WAIT;
         S_SCALE_WAIT: if (div_done) state_in = S_SCALE;
         S_FRAC: begin
            if (rem_ff == '0 || frac_col >= COL_W'(lim_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FSUB;
            end
         end
         S_FSUB: if (rem_ff < y_ff) state_in = S_FRAC;
         S_APPEND: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and unit controls.
   always_comb begin
      kind_in   = kind_ff;
      digit_in  = digit_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      rem_in    = rem_ff;
      xp_in     = xp_ff;
      yp_in     = yp_ff;
      pt_in     = pt_ff;
      d_in      = d_ff;
      sg_in     = sg_ff;
      ill_in    = ill_ff;
      acc_in    = acc_ff;
      sub_in    = sub_ff;
      cnt_in    = cnt_ff;
      pow_in    = pow_ff;
      div_start = 1'b0;
      mul_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               digit_in = req_digit;
               ill_in   = 1'b0;
               acc_in   = 1'b0;
               sub_in   = eff_sub;
               x_in     = '0;
               pt_in    = '0;
               sg_in    = 1'b0;
               case (req_kind)
                  KIND_ADD, KIND_SUB: begin
                     x_in  = swap ? W'(req_b_magnitude) : W'(req_a_magnitude);
                     xp_in = swap ? req_b_point : req_a_point;
                     y_in  = swap ? W'(req_a_magnitude) : W'(req_b_magnitude);
                     yp_in = swap ? req_a_point : req_b_point;
                     sg_in = (eff_sub && req_kind == KIND_ADD) ? 1'b0 : req_a_sign;
                     if (eff_sub && req_a_magnitude == req_b_magnitude &&
                         req_a_point == req_b_point) begin
                        x_in  = '0;
                        sg_in = 1'b0;
                     end
                  end
                  KIND_MUL: begin
                     mul_start = 1'b1;
                     pt_in     = RPT_W'(req_a_point) + RPT_W'(req_b_point);
                     sg_in     = req_a_sign ^ req_b_sign;
                  end
                  KIND_DIV: begin
                     if (req_b_magnitude == '0) begin
                        ill_in = 1'b1;
                     end else begin
                        x_in  = W'(req_a_magnitude);
                        xp_in = req_a_point;
                        y_in  = W'(req_b_magnitude);
                        yp_in = req_b_point;
                        sg_in = req_a_sign ^ req_b_sign;
                     end
                  end
                  KIND_APP_INT, KIND_APP_FRAC: begin
                     x_in  = W'(req_a_magnitude);
                     pt_in = RPT_W'(req_a_point);
                     sg_in = req_a_sign;
                  end
                  default: begin
                     x_in = '0;
                  end
               endcase
            end
         end
         S_ALIGN: begin
            if (xp_ff < yp_ff) begin
               x_in  = x10;
               xp_in = xp_ff + PT_W'(1);
            end else if (yp_ff < xp_ff) begin
               y_in  = y10;
               yp_in = yp_ff + PT_W'(1);
            end else begin
               pt_in = RPT_W'(xp_ff);
            end
         end
         S_ARITH: begin
            if (!sub_ff) begin
               x_in = x_ff + y_ff;
            end else if (x_ff < y_ff) begin
               x_in  = y_ff - x_ff;
               sg_in = !sg_ff;
            end else begin
               x_in = x_ff - y_ff;
            end
         end
         S_DCHK: begin
            if (y_ff == '0) begin
               x_in   = '0;
               pt_in  = '0;
               sg_in  = 1'b0;
               ill_in = 1'b1;
            end else begin
               div_start = 1'b1;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               x_in   = div_quot;
               rem_in = div_rem;
               pt_in  = '0;
            end
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               x_in = mul_prod;
            end
         end
         S_TRIM: begin
            if (pt_ff != '0) begin
               div_start = 1'b1;
            end
         end
         S_TRIM_WAIT: begin
            if (div_done && div_rem == '0) begin
               x_in  = div_quot;
               pt_in = pt_ff - RPT_W'(1);
            end
         end
         S_CINIT: begin
            cnt_in = CNT_W'(1);
            pow_in = POW_W'(10);
         end
         S_COUNT: begin
            if (ge_pow) begin
               cnt_in = cnt_next;
               if (!over_lim) begin
                  pow_in = pow10;
               end
            end
         end
         S_CUT: begin
            if (cut_ok) begin
               d_in  = RPT_W'(cut_d);
               pt_in = pt_ff - RPT_W'(cut_d);
            end
         end
         S_SCALE: begin
            if (d_ff != '0) begin
               div_start = 1'b1;
            end
         end
         S_SCALE_WAIT: begin
            if (div_done) begin
               x_in = div_quot;
               d_in = d_ff - RPT_W'(1);
            end
         end
         S_FRAC: begin
            if (rem_ff != '0 && frac_col < COL_W'(lim_ff)) begin
               rem_in = rem10;
               x_in   = x10;
               pt_in  = pt_ff + RPT_W'(1);
            end
         end
         S_FSUB: begin
            // The next quotient digit is found by at most nine subtractions.
            if (rem_ff >= y_ff) begin
               rem_in = rem_ff - y_ff;
               x_in   = x_ff + W'(1);
            end
         end
         S_APPEND: begin
            if (tot_col < COL_W'(lim_ff)) begin
               acc_in = 1'b1;
               if (kind_ff == KIND_APP_FRAC || pt_ff == '0) begin
                  x_in = x10 + W'(digit_ff);
               end
               if (kind_ff == KIND_APP_FRAC) begin
                  pt_in = pt_ff + RPT_W'(1);
               end
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   assign busy            = state_ff != S_IDLE;
   assign csr_ready       = state_ff == S_IDLE;
   assign rsp_valid       = state_ff == S_DONE;
   assign rsp_r_magnitude = RMAG_W'(x_ff);
   assign rsp_r_point     = pt_ff;
   assign rsp_r_sign      = sg_ff;
   assign rsp_illegal     = ill_ff;
   assign rsp_accepted    = acc_ff;

   `DCALC_ASSERT_NXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe longer than a cycle")
   `DCALC_ASSERT_IMP(a_illegal_zero, rsp_valid && rsp_illegal, rsp_r_magnitude == '0 && rsp_r_point == '0 && !rsp_r_sign, "illegal result not zero")
   `DCALC_ASSERT_IMP(a_accept_kind, rsp_valid && rsp_accepted, kind_ff == KIND_APP_INT || kind_ff == KIND_APP_FRAC, "accepted set outside digit append")
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for decimal_calculator_arithmetic_unit.
// Depends on dcalc_pkg and the unit; predicts each result in place and checks it on the strobe.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import dcalc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 40000;

   typedef struct {
      logic [63:0] mag;
      int unsigned pt;
      bit          sg;
   } dec_num_t;

   typedef struct {
      logic [RMAG_W-1:0] mag;
      logic [RPT_W-1:0]  pt;
      bit                sg;
      bit                ill;
      bit                acc;
   } calc_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KIND_W-1:0]  req_kind = '0;
   logic [OPND_W-1:0]  req_a_magnitude = '0;
   logic [PT_W-1:0]    req_a_point = '0;
   logic               req_a_sign = 1'b0;
   logic [OPND_W-1:0]  req_b_magnitude = '0;
   logic [PT_W-1:0]    req_b_point = '0;
   logic               req_b_sign = 1'b0;
   logic [DIGIT_W-1:0] req_digit = '0;
   logic               rsp_valid;
   logic [RMAG_W-1:0]  rsp_r_magnitude;
   logic [RPT_W-1:0]   rsp_r_point;
   logic               rsp_r_sign;
   logic               rsp_illegal;
   logic               rsp_accepted;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIM_W-1:0]   csr_column_limit = '0;

   calc_result_t pending_results[$];
   int unsigned  col_limit = 10;
   int           sender_idle = 0;
   int           errors = 0;
   int           stall_cycles = 0;
   dec_num_t     last_result;

   always #6 clock = ~clock;

   decimal_calculator_arithmetic_unit dut (
      .clock, .reset, .start, .busy,
      .req_kind, .req_a_magnitude, .req_a_point, .req_a_sign,
      .req_b_magnitude, .req_b_point, .req_b_sign, .req_digit,
      .rsp_valid, .rsp_r_magnitude, .rsp_r_point, .rsp_r_sign, .rsp_illegal, .rsp_accepted,
      .csr_valid, .csr_ready, .csr_column_limit
   );

   // ---------------- prediction ----------------
   function automatic int unsigned int_columns(dec_num_t n);
      logic [63:0] r;
      int unsigned c;
      r = 64'd10;
      c = 1;
      while (n.mag >= r) begin
         c++;
         if (c > col_limit) break;
         r = r * 64'd10;
      end
      c = (c > n.pt) ? c - n.pt : 1;
      return c + n.sg;
   endfunction

   function automatic dec_num_t fit_columns(dec_num_t n);
      int unsigned col, d;
      if (n.pt != 0) begin
         while (n.mag % 10 == 0) begin
            n.mag = n.mag / 10;
            n.pt--;
            if (n.pt == 0) break;
         end
      end
      col = int_columns(n);
      if (n.pt != 0) begin
         col += 1 + n.pt;
         if (col > col_limit) begin
            d = col - col_limit;
            // A cut deeper than the fraction leaves the number alone.
            if (d <= n.pt) begin
               repeat (d) n.mag = n.mag / 10;
               n.pt -= d;
            end
         end
      end
      return n;
   endfunction

   function automatic void align_points(input dec_num_t a, input dec_num_t b,
                                        output dec_num_t l, output dec_num_t r);
      l = a;
      r = b;
      if (l.pt < r.pt) begin
         repeat (r.pt - l.pt) l.mag = l.mag * 64'd10;
         l.pt = r.pt;
      end else begin
         repeat (l.pt - r.pt) r.mag = r.mag * 64'd10;
         r.pt = l.pt;
      end
   endfunction

   function automatic dec_num_t add_magnitudes(dec_num_t a, dec_num_t b);
      dec_num_t l, r, s;
      align_points(a, b, l, r);
      s.mag = l.mag + r.mag;
      s.pt = l.pt;
      s.sg = l.sg;
      return fit_columns(s);
   endfunction

   function automatic dec_num_t sub_magnitudes(dec_num_t a, dec_num_t b);
      dec_num_t l, r, s;
      if (a.mag == b.mag && a.pt == b.pt) begin
         s.mag = 0; s.pt = 0; s.sg = 0;
         return s;
      end
      align_points(a, b, l, r);
      if (l.mag < r.mag) begin
         s.mag = r.mag - l.mag;
         s.sg = ~l.sg;
      end else begin
         s.mag = l.mag - r.mag;
         s.sg = l.sg;
      end
      s.pt = l.pt;
      return fit_columns(s);
   endfunction

   function automatic calc_result_t calculate(logic [KIND_W-1:0] kind, dec_num_t a, dec_num_t b,
                                              logic [3:0] dg);
      calc_result_t o;
      dec_num_t s, t, l, r;
      logic [63:0] rem;
      int unsigned col;
      s.mag = 0; s.pt = 0; s.sg = 0;
      o.ill = 0;
      o.acc = 0;
      case (kind)
         KIND_ADD: begin
            if (a.sg == b.sg) s = add_magnitudes(a, b);
            else if (a.sg == 0) begin t = b; t.sg = 0; s = sub_magnitudes(a, t); end
            else begin t = a; t.sg = 0; s = sub_magnitudes(b, t); end
         end
         KIND_SUB: begin
            if (a.sg != b.sg) begin t = b; t.sg = ~t.sg; s = add_magnitudes(a, t); end
            else s = sub_magnitudes(a, b);
         end
         KIND_MUL: begin
            s.mag = a.mag * b.mag;
            s.pt = a.pt + b.pt;
            s.sg = a.sg ^ b.sg;
            s = fit_columns(s);
         end
         KIND_DIV: begin
            align_points(a, b, l, r);
            // A divisor that wraps to zero during alignment counts as zero too.
            if (b.mag == 0 || r.mag == 0) o.ill = 1;
            else begin
               s.sg = l.sg ^ r.sg;
               s.mag = l.mag / r.mag;
               rem = l.mag % r.mag;
               col = int_columns(s);
               while (rem != 0) begin
                  if (col + 1 + s.pt >= col_limit) break;
                  rem = rem * 64'd10;
                  s.mag = s.mag * 64'd10 + rem / r.mag;
                  s.pt++;
                  rem = rem % r.mag;
               end
            end
         end
         KIND_APP_INT, KIND_APP_FRAC: begin
            s = a;
            col = int_columns(a) + ((a.pt != 0) ? 1 + a.pt : 0);
            if (col < col_limit) begin
               o.acc = 1;
               if (kind == KIND_APP_FRAC || a.pt == 0) s.mag = a.mag * 64'd10 + dg;
               if (kind == KIND_APP_FRAC) s.pt = a.pt + 1;
            end
         end
         default: ;
      endcase
      o.mag = s.mag;
      o.pt = s.pt[RPT_W-1:0];
      o.sg = s.sg;
      return o;
   endfunction

   // ---------------- driving ----------------
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [OPND_W-1:0] am, input logic [PT_W-1:0] ap,
                            input bit asg, input logic [OPND_W-1:0] bm,
                            input logic [PT_W-1:0] bp, input bit bsg,
                            input logic [DIGIT_W-1:0] dg);
      int gap;
      dec_num_t a, b;
      calc_result_t o;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_a_magnitude <= am; req_a_point <= ap; req_a_sign <= asg;
      req_b_magnitude <= bm; req_b_point <= bp; req_b_sign <= bsg;
      req_digit <= dg;
      do @(negedge clock); while (busy);
      // The item goes in at the coming rising edge.
      a.mag = am; a.pt = ap; a.sg = asg;
      b.mag = bm; b.pt = bp; b.sg = bsg;
      o = calculate(kind, a, b, dg);
      pending_results.push_back(o);
      last_result.mag = o.mag; last_result.pt = o.pt; last_result.sg = o.sg;
      @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_column_limit(input logic [LIM_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_column_limit <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      col_limit = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [OPND_W-1:0] rand_magnitude();
      logic [63:0] span, v;
      int n;
      n = $urandom_range(0, 11);
      v = {$urandom, $urandom};
      if (n == 11) return v[OPND_W-1:0];
      span = 1;
      repeat (n) span = span * 10;
      return OPND_W'(v % span);
   endfunction

   function automatic logic [PT_W-1:0] rand_point();
      return ($urandom_range(0, 9) == 0) ? PT_W'($urandom_range(0, 15))
                                         : PT_W'($urandom_range(0, 10));
   endfunction

   // ---------------- checking ----------------
   always @(negedge clock) begin
      calc_result_t e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, magnitude %0d", $realtime,
                     rsp_r_magnitude);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_r_magnitude !== e.mag) begin
               $display("%0t: magnitude expected %0d got %0d", $realtime, e.mag, rsp_r_magnitude);
               errors++;
            end
            if (rsp_r_point !== e.pt) begin
               $display("%0t: point expected %0d got %0d", $realtime, e.pt, rsp_r_point);
               errors++;
            end
            if (rsp_r_sign !== e.sg) begin
               $display("%0t: sign expected %0d got %0d", $realtime, e.sg, rsp_r_sign);
               errors++;
            end
            if (rsp_illegal !== e.ill) begin
               $display("%0t: illegal expected %0d got %0d", $realtime, e.ill, rsp_illegal);
               errors++;
            end
            if (rsp_accepted !== e.acc) begin
               $display("%0t: accepted expected %0d got %0d", $realtime, e.acc, rsp_accepted);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake of any kind completes.
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_add_sub();
      send_item(KIND_ADD, 34'd0, 4'd0, 0, 34'd0, 4'd0, 0, 4'd0);
      send_item(KIND_ADD, 34'h3_FFFF_FFFF, 4'd15, 1, 34'h3_FFFF_FFFF, 4'd0, 1, 4'd0);
      send_item(KIND_ADD, 34'd1250, 4'd2, 0, 34'd75, 4'd1, 1, 4'd0);
      send_item(KIND_ADD, 34'd500, 4'd3, 1, 34'd2, 4'd0, 0, 4'd0);
      send_item(KIND_SUB, 34'd1234, 4'd2, 1, 34'd1234, 4'd2, 1, 4'd0);
      send_item(KIND_SUB, 34'd1, 4'd0, 0, 34'd9999999999, 4'd10, 0, 4'd0);
      send_item(KIND_SUB, 34'd9999999999, 4'd0, 0, 34'd1, 4'd10, 1, 4'd0);
      send_item(KIND_SUB, 34'd10, 4'd1, 0, 34'd100, 4'd2, 0, 4'd0);
   endtask

   task automatic test_mul_div();
      send_item(KIND_MUL, 34'd9999999999, 4'd10, 1, 34'd9999999999, 4'd10, 0, 4'd0);
      send_item(KIND_MUL, 34'h3_FFFF_FFFF, 4'd0, 0, 34'h3_FFFF_FFFF, 4'd0, 1, 4'd0);
      send_item(KIND_MUL, 34'd125, 4'd1, 0, 34'd8, 4'd1, 0, 4'd0);
      send_item(KIND_DIV, 34'd1, 4'd0, 0, 34'd3, 4'd0, 0, 4'd0);
      send_item(KIND_DIV, 34'd22, 4'd0, 1, 34'd7, 4'd0, 0, 4'd0);
      send_item(KIND_DIV, 34'd5, 4'd0, 0, 34'd0, 4'd3, 1, 4'd0);
      // A divisor of 2^34 scaled by 10^15 wraps in 64 bits, but not to zero.
      send_item(KIND_DIV, 34'd7, 4'd15, 0, 34'h2_0000_0000, 4'd0, 0, 4'd0);
      send_item(KIND_DIV, 34'd9999999999, 4'd0, 0, 34'd1, 4'd10, 1, 4'd0);
   endtask

   task automatic test_append();
      send_item(KIND_APP_INT, 34'd12, 4'd0, 0, 34'd0, 4'd0, 0, 4'd9);
      send_item(KIND_APP_INT, 34'd12, 4'd1, 1, 34'd0, 4'd0, 0, 4'd5);
      send_item(KIND_APP_INT, 34'd999999999, 4'd0, 1, 34'd0, 4'd0, 0, 4'd1);
      send_item(KIND_APP_FRAC, 34'd3, 4'd0, 0, 34'd0, 4'd0, 0, 4'd15);
      send_item(KIND_APP_FRAC, 34'd12345678, 4'd0, 0, 34'd0, 4'd0, 0, 4'd4);
      send_item(KIND_SPARE_LO, 34'd77, 4'd3, 1, 34'd5, 4'd2, 1, 4'd7);
      send_item(KIND_SPARE_HI, 34'd77, 4'd3, 1, 34'd5, 4'd2, 1, 4'd7);
   endtask

   task automatic test_column_limits();
      write_column_limit(4'd1);
      send_item(KIND_ADD, 34'd125, 4'd2, 0, 34'd1, 4'd1, 0, 4'd0);
      send_item(KIND_DIV, 34'd1, 4'd0, 0, 34'd7, 4'd0, 0, 4'd0);
      send_item(KIND_APP_INT, 34'd0, 4'd0, 0, 34'd0, 4'd0, 0, 4'd3);
      write_column_limit(4'd15);
      send_item(KIND_DIV, 34'd1, 4'd0, 0, 34'd7, 4'd0, 0, 4'd0);
      write_column_limit(4'd0);
      send_item(KIND_MUL, 34'd15, 4'd1, 0, 34'd15, 4'd1, 0, 4'd0);
      write_column_limit(4'd10);
   endtask

   // Keypress-like sequence: digits typed into the previous result.
   task automatic type_number();
      dec_num_t n;
      int len;
      bit frac;
      n.mag = 0; n.pt = 0; n.sg = $urandom_range(0, 1);
      frac = 0;
      len = $urandom_range(2, 10);
      repeat (len) begin
         if (!frac && $urandom_range(0, 3) == 0) frac = 1;
         send_item(frac ? KIND_APP_FRAC : KIND_APP_INT, n.mag[OPND_W-1:0], n.pt[PT_W-1:0],
                   n.sg, rand_magnitude(), rand_point(), $urandom_range(0, 1),
                   ($urandom_range(0, 19) == 0) ? DIGIT_W'($urandom_range(10, 15))
                                                : DIGIT_W'($urandom_range(0, 9)));
         n = last_result;
      end
   endtask

   task automatic test_random(input int count, input int idle_pct);
      int sent;
      logic [KIND_W-1:0] k;
      sender_idle = idle_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 149) == 0)
            write_column_limit(($urandom_range(0, 9) == 0) ? LIM_W'($urandom_range(0, 15))
                                                          : LIM_W'($urandom_range(1, 10)));
         if ($urandom_range(0, 9) == 0) begin
            type_number();
            sent += 6;
         end else begin
            k = ($urandom_range(0, 29) == 0) ? KIND_W'($urandom_range(6, 7))
                                             : KIND_W'($urandom_range(0, 5));
            send_item(k, rand_magnitude(), rand_point(), $urandom_range(0, 1),
                      rand_magnitude(), rand_point(), $urandom_range(0, 1),
                      DIGIT_W'($urandom_range(0, 15)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle = 0;
      test_add_sub();
      test_mul_div();
      test_append();
      test_column_limits();
      test_random(650, 35);
      // Let every result come back before the sender carries on.
      drain_results();
      test_random(650, 73);
      test_random(650, 0);
      drain_results();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
